@@ rtl/ylmg_pkg.sv @@
`default_nettype none
package ylmg_pkg;

  localparam int unsigned GammaPoints = 17;
  localparam int unsigned GammaTables = 3;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_L0_CTRL = 3'd0,
    REG_L1_CTRL = 3'd1,
    REG_KEY0    = 3'd2,
    REG_KEY1    = 3'd3,
    REG_RATIO0  = 3'd4,
    REG_RATIO1  = 3'd5,
    REG_GAMMA   = 3'd6,
    REG_NONE    = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OVL_TRANSP = 2'd0,
    OVL_AND    = 2'd1,
    OVL_OR     = 2'd2,
    OVL_INV    = 2'd3
  } ovl_e;

  // register block snapshot passed to the back end
  typedef struct packed {
    logic [4:0]  ctrl0;
    logic [4:0]  ctrl1;
    logic [23:0] key0;
    logic [23:0] key1;
    logic [8:0]  ratio0;
    logic [8:0]  ratio1;
    logic        gamma_en;
  } cfg_t;

  // one classified transaction in the queue; table writes travel in order too
  typedef struct packed {
    logic [23:0] video0;
    logic [23:0] video1;
    logic [23:0] gfx0;
    logic [23:0] gfx1;
    logic [1:0]  src0;
    logic [1:0]  src1;
    logic        tw;
    logic [1:0]  tw_chan;
    logic [4:0]  tw_idx;
    logic [7:0]  tw_val;
  } job_t;

  typedef logic [7:0] gtab_t [GammaPoints];

  function automatic logic [7:0] gamma_default(input logic [4:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0: r = 8'h03;  5'd1: r = 8'h13;  5'd2: r = 8'h2b;  5'd3: r = 8'h48;
      5'd4: r = 8'h62;  5'd5: r = 8'h7b;  5'd6: r = 8'h93;  5'd7: r = 8'ha8;
      5'd8: r = 8'hba;  5'd9: r = 8'hca;  5'd10: r = 8'hd7; 5'd11: r = 8'he3;
      5'd12: r = 8'hec; 5'd13: r = 8'hf4; 5'd14: r = 8'hfa; 5'd15: r = 8'hff;
      default: r = 8'hff;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 12'sd255) r = 8'hff;
    else r = v[7:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ylmg_in_if.sv @@
`default_nettype none
interface ylmg_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  luma_first;
  logic [7:0]  chroma_u;
  logic [7:0]  luma_second;
  logic [7:0]  chroma_v;
  logic [23:0] gfx_pixel_first;
  logic [1:0]  gfx_source_first;
  logic [23:0] gfx_pixel_second;
  logic [1:0]  gfx_source_second;
  logic [1:0]  table_channel;
  logic [4:0]  table_index;
  logic [7:0]  table_value;
  modport source (output valid, opcode, luma_first, chroma_u, luma_second, chroma_v,
                  gfx_pixel_first, gfx_source_first, gfx_pixel_second,
                  gfx_source_second, table_channel, table_index, table_value,
                  input ready);
  modport sink (input valid, opcode, luma_first, chroma_u, luma_second, chroma_v,
                gfx_pixel_first, gfx_source_first, gfx_pixel_second,
                gfx_source_second, table_channel, table_index, table_value,
                output ready);
endinterface
`default_nettype wire

@@ rtl/ylmg_out_if.sv @@
`default_nettype none
interface ylmg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rgb_first;
  logic [23:0] rgb_second;
  modport source (output valid, rgb_first, rgb_second, input ready);
  modport sink (input valid, rgb_first, rgb_second, output ready);
endinterface
`default_nettype wire

@@ rtl/ylmg_front.sv @@
`default_nettype none
module ylmg_front
  import ylmg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ylmg_in_if.sink   in_if,
  input  wire logic q_ready_i,
  output logic      q_valid_o,
  output job_t      q_job_o
);

  logic       hold_q;
  job_t       job_q;
  logic       acc;
  logic [7:0] r0, g0, b0, r1, g1, b1;

  // chroma terms shared by both pixels
  logic [16:0] rv, gu, gv, bu;
  logic [8:0]  rt, gt, bt;
  logic [17:0] gs;
  assign rv = 17'(9'd359 * in_if.chroma_v);
  assign gu = 17'(7'd88 * in_if.chroma_u);
  assign gv = 17'(8'd183 * in_if.chroma_v);
  assign bu = 17'(9'd454 * in_if.chroma_u);
  assign gs = {1'b0, gu} + {1'b0, gv};
  assign rt = rv[16:8];
  assign gt = gs[16:8];
  assign bt = bu[16:8];

  function automatic logic [23:0] conv(input logic [7:0] y, input logic [8:0] a,
                                       input logic [8:0] c, input logic [8:0] d);
    logic signed [11:0] ys;
    ys = $signed({4'd0, y});
    return {clamp8(ys + $signed({3'd0, a}) - 12'sd179),
            clamp8(ys + 12'sd135 - $signed({3'd0, c})),
            clamp8(ys + $signed({3'd0, d}) - 12'sd227)};
  endfunction

  // single-entry holding register as the queue slot; ready when it drains
  assign in_if.ready = !hold_q || q_ready_i;
  assign acc = in_if.valid && in_if.ready;
  assign q_valid_o = hold_q;
  assign q_job_o = job_q;

  assign {r0, g0, b0} = conv(in_if.luma_first, rt, gt, bt);
  assign {r1, g1, b1} = conv(in_if.luma_second, rt, gt, bt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (in_if.ready) begin
      hold_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      job_q.video0  <= {r0, g0, b0};
      job_q.video1  <= {r1, g1, b1};
      job_q.gfx0    <= in_if.gfx_pixel_first;
      job_q.gfx1    <= in_if.gfx_pixel_second;
      job_q.src0    <= in_if.gfx_source_first;
      job_q.src1    <= in_if.gfx_source_second;
      job_q.tw      <= (in_if.opcode == OP_TABLE);
      job_q.tw_chan <= in_if.table_channel;
      job_q.tw_idx  <= in_if.table_index;
      job_q.tw_val  <= in_if.table_value;
    end
  end

  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q && !q_ready_i |=> hold_q && $stable(job_q))
    else $error("queue slot lost a stalled job");
  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> hold_q)
    else $error("accepted transaction not queued");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_q |-> in_if.ready)
    else $error("front stalled while empty");

endmodule
`default_nettype wire

@@ rtl/ylmg_back.sv @@
`default_nettype none
module ylmg_back
  import ylmg_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  q_valid_i,
  output logic       q_ready_o,
  input  job_t       q_job_i,
  ylmg_out_if.source out_if
);

  // stage 1: mix, registered; stage 2: gamma into output register
  logic        s1_v_q, out_v_q, adv1, adv2;
  logic [23:0] m0_q, m1_q, o0_q, o1_q;
  logic        g_q;
  // table write carried through stage 1 so it lands in transaction order
  logic        s1_tw_q;
  logic [1:0]  s1_chan_q;
  logic [4:0]  s1_idx_q;
  logic [7:0]  s1_val_q;

  // gamma tables: 51 bytes of flops, each a fixed tap
  logic [7:0] gt_q [GammaTables][GammaPoints];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < GammaTables; c++)
        for (int i = 0; i < GammaPoints; i++)
          gt_q[c][i] <= gamma_default(5'(i));
    end else if (adv2 && s1_v_q && s1_tw_q && s1_chan_q < 2'(GammaTables) &&
                 s1_idx_q < 5'(GammaPoints)) begin
      gt_q[s1_chan_q][s1_idx_q] <= s1_val_q;
    end
  end

  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] r);
    logic [16:0] s;
    s = 17'(a * r) + 17'(b * (9'd256 - r));
    return s[15:8];
  endfunction

  function automatic logic [23:0] mix(input logic [23:0] vid, input logic [23:0] gfx,
                                      input logic [1:0] src, input cfg_t cfg);
    logic [4:0]  ctl;
    logic [23:0] key, fr, bk, res;
    logic [8:0]  rat;
    ctl = (src == 2'd2) ? cfg.ctrl1 : cfg.ctrl0;
    key = (src == 2'd2) ? cfg.key1 : cfg.key0;
    rat = (src == 2'd2) ? cfg.ratio1 : cfg.ratio0;
    if (rat > 9'd256) rat = 9'd256;
    fr = ctl[4] ? gfx : vid;
    bk = ctl[4] ? vid : gfx;
    res = vid;
    if (src == 2'd1 || src == 2'd2) begin
      if (ctl[0]) begin
        res = {blend8(vid[23:16], gfx[23:16], rat), blend8(vid[15:8], gfx[15:8], rat),
               blend8(vid[7:0], gfx[7:0], rat)};
      end else if (ctl[1]) begin
        if (fr != key) res = fr;
        else begin
          unique case (ovl_e'(ctl[3:2]))
            OVL_TRANSP: res = bk;
            OVL_AND:    res = fr & bk;
            OVL_OR:     res = fr | bk;
            OVL_INV:    res = ~bk;
          endcase
        end
      end
    end
    return res;
  endfunction

  assign adv2 = !out_v_q || out_if.ready;
  assign adv1 = !s1_v_q || adv2;
  assign q_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= q_valid_i;
      if (adv2) out_v_q <= s1_v_q && !s1_tw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && q_valid_i) begin
      m0_q      <= mix(q_job_i.video0, q_job_i.gfx0, q_job_i.src0, cfg_i);
      m1_q      <= mix(q_job_i.video1, q_job_i.gfx1, q_job_i.src1, cfg_i);
      g_q       <= cfg_i.gamma_en;
      s1_tw_q   <= q_job_i.tw;
      s1_chan_q <= q_job_i.tw_chan;
      s1_idx_q  <= q_job_i.tw_idx;
      s1_val_q  <= q_job_i.tw_val;
    end
  end

  function automatic logic [7:0] gam(input logic [7:0] x, input logic [7:0] lo,
                                     input logic [7:0] hi);
    logic signed [12:0] d;
    logic signed [12:0] v;
    d = ($signed({5'd0, hi}) - $signed({5'd0, lo})) * $signed({9'd0, x[3:0]});
    v = $signed({5'd0, lo}) + (d >>> 4);
    return clamp8(v[11:0]);
  endfunction

  logic [23:0] g0, g1;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g0[8*k +: 8] = gam(m0_q[8*k +: 8], gt_q[k][5'(m0_q[8*k+4 +: 4])],
                         gt_q[k][5'(m0_q[8*k+4 +: 4]) + 5'd1]);
      g1[8*k +: 8] = gam(m1_q[8*k +: 8], gt_q[k][5'(m1_q[8*k+4 +: 4])],
                         gt_q[k][5'(m1_q[8*k+4 +: 4]) + 5'd1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q && !s1_tw_q) begin
      o0_q <= g_q ? g0 : m0_q;
      o1_q <= g_q ? g1 : m1_q;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.rgb_first  = o0_q;
  assign out_if.rgb_second = o1_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_if.ready |=> out_v_q && $stable(o0_q))
    else $error("stalled result changed");
  a_s1_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_tw_q && adv2 |=> out_v_q)
    else $error("mixed pixel lost");
  a_q_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i && q_ready_o |=> s1_v_q)
    else $error("queued job dropped");

endmodule
`default_nettype wire

@@ rtl/yuv_layer_mix_gamma.sv @@
// Path: convert into the queue slot, mix into stage 1, gamma into the output register.
// Throughput: one pixel pair per cycle unless the output stalls; a table write gives no result.
// Output register and one-slot queue between convert and mix decouple the sides.
// Reset (rst_ni, async low): config registers to 0, gamma tables to the default curve,
// all pipeline slots empty.
`default_nettype none
module yuv_layer_mix_gamma
  import ylmg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ylmg_in_if.sink          in_if,
  ylmg_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_q;
  reg_e ra;

  assign pready = 1'b1;
  assign ra = reg_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        REG_L0_CTRL: cfg_q.ctrl0    <= pwdata[4:0];
        REG_L1_CTRL: cfg_q.ctrl1    <= pwdata[4:0];
        REG_KEY0:    cfg_q.key0     <= pwdata[23:0];
        REG_KEY1:    cfg_q.key1     <= pwdata[23:0];
        REG_RATIO0:  cfg_q.ratio0   <= pwdata[8:0];
        REG_RATIO1:  cfg_q.ratio1   <= pwdata[8:0];
        REG_GAMMA:   cfg_q.gamma_en <= pwdata[0];
        REG_NONE:    ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ra)
      REG_L0_CTRL: prdata = {27'd0, cfg_q.ctrl0};
      REG_L1_CTRL: prdata = {27'd0, cfg_q.ctrl1};
      REG_KEY0:    prdata = {8'd0, cfg_q.key0};
      REG_KEY1:    prdata = {8'd0, cfg_q.key1};
      REG_RATIO0:  prdata = {23'd0, cfg_q.ratio0};
      REG_RATIO1:  prdata = {23'd0, cfg_q.ratio1};
      REG_GAMMA:   prdata = {31'd0, cfg_q.gamma_en};
      REG_NONE:    prdata = 32'd0;
    endcase
  end

  logic       q_valid, q_ready;
  job_t       q_job;

  ylmg_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_ready_i(q_ready), .q_valid_o(q_valid), .q_job_o(q_job)
  );

  ylmg_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_job_i(q_job),
    .out_if
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ylmg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ylmg_in_if in_if ();
  ylmg_out_if out_if ();

  yuv_layer_mix_gamma dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    opcode_e     op;
    logic [7:0]  y0, u, y1, v;
    logic [23:0] g0;
    logic [1:0]  s0;
    logic [23:0] g1;
    logic [1:0]  s1;
    logic [1:0]  ch;
    logic [4:0]  idx;
    logic [7:0]  val;
  } pix_item_t;

  typedef struct {
    logic [23:0] p0, p1;
  } rgb_pair_t;

  // shadow of register block and gamma tables
  logic [4:0]  m_ctrl [2];
  logic [23:0] m_key [2];
  logic [8:0]  m_ratio [2];
  logic        m_gamma_en;
  logic [7:0]  m_curve [GammaTables][GammaPoints];

  rgb_pair_t pending_rgb [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic logic [7:0] sat8(int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'hff;
    return x[7:0];
  endfunction

  function automatic logic [23:0] yuv_to_rgb(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    int yy, uu, vv;
    logic [7:0] r, g, b;
    yy = y; uu = u; vv = v;
    r = sat8(yy + ((359 * vv) >>> 8) - 179);
    g = sat8(yy + 135 - ((88 * uu + 183 * vv) >>> 8));
    b = sat8(yy + ((454 * uu) >>> 8) - 227);
    return {r, g, b};
  endfunction

  function automatic logic [23:0] layer_mix(logic [23:0] vid, logic [23:0] gfx,
                                            logic [1:0] src);
    logic [4:0] c;
    int unsigned ra, a, b;
    logic [23:0] fr, bk, res;
    if (src != 2'd1 && src != 2'd2) return vid;
    c = m_ctrl[src - 1];
    if (c[0]) begin
      ra = m_ratio[src - 1];
      if (ra > 256) ra = 256;
      for (int k = 0; k < 3; k++) begin
        a = vid[8*k +: 8];
        b = gfx[8*k +: 8];
        res[8*k +: 8] = 8'((a * ra + b * (256 - ra)) >> 8);
      end
      return res;
    end
    if (!c[1]) return vid;
    fr = c[4] ? gfx : vid;
    bk = c[4] ? vid : gfx;
    if (fr != m_key[src - 1]) return fr;
    case (ovl_e'(c[3:2]))
      OVL_TRANSP: return bk;
      OVL_AND:    return fr & bk;
      OVL_OR:     return fr | bk;
      default:    return ~bk;
    endcase
  endfunction

  function automatic logic [23:0] gamma_correct(logic [23:0] pix);
    logic [23:0] res;
    int x, p, f, d, q;
    for (int k = 0; k < 3; k++) begin
      x = pix[8*k +: 8];
      p = x >> 4;
      f = x & 15;
      d = (int'(m_curve[k][p + 1]) - int'(m_curve[k][p])) * f;
      q = (d >= 0) ? d / 16 : -((-d + 15) / 16);
      res[8*k +: 8] = sat8(int'(m_curve[k][p]) + q);
    end
    return res;
  endfunction

  // apply one accepted transaction to the shadow and queue its pixels
  function automatic void predict_pixels(pix_item_t it);
    rgb_pair_t e;
    if (it.op == OP_TABLE) begin
      if (it.ch < GammaTables && it.idx < GammaPoints) m_curve[it.ch][it.idx] = it.val;
      return;
    end
    e.p0 = layer_mix(yuv_to_rgb(it.y0, it.u, it.v), it.g0, it.s0);
    e.p1 = layer_mix(yuv_to_rgb(it.y1, it.u, it.v), it.g1, it.s1);
    if (m_gamma_en) begin
      e.p0 = gamma_correct(e.p0);
      e.p1 = gamma_correct(e.p1);
    end
    pending_rgb.push_back(e);
  endfunction

  function automatic void flag_mismatch(string what, logic [23:0] exp_v, logic [23:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %06h got %06h", what, exp_v, act_v);
  endfunction

  // register write via APB, only while idle
  task automatic reg_write(reg_e r, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_L0_CTRL: m_ctrl[0] = d[4:0];
      REG_L1_CTRL: m_ctrl[1] = d[4:0];
      REG_KEY0:    m_key[0] = d[23:0];
      REG_KEY1:    m_key[1] = d[23:0];
      REG_RATIO0:  m_ratio[0] = d[8:0];
      REG_RATIO1:  m_ratio[1] = d[8:0];
      REG_GAMMA:   m_gamma_en = d[0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // send one transaction; valid stays high, the caller drops it before a gap
  task automatic send_pixels(pix_item_t it);
    in_if.valid <= 1'b1;
    in_if.opcode <= it.op;
    in_if.luma_first <= it.y0; in_if.chroma_u <= it.u;
    in_if.luma_second <= it.y1; in_if.chroma_v <= it.v;
    in_if.gfx_pixel_first <= it.g0; in_if.gfx_source_first <= it.s0;
    in_if.gfx_pixel_second <= it.g1; in_if.gfx_source_second <= it.s1;
    in_if.table_channel <= it.ch; in_if.table_index <= it.idx;
    in_if.table_value <= it.val;
    do @(posedge clk_i); while (!in_if.ready);
    predict_pixels(it);
  endtask

  function automatic pix_item_t rand_item();
    pix_item_t it;
    it.op = ($urandom_range(0, 15) == 0) ? OP_TABLE : OP_PIXEL;
    it.y0 = $urandom; it.u = $urandom; it.y1 = $urandom; it.v = $urandom;
    it.g0 = $urandom; it.g1 = $urandom;
    it.s0 = $urandom_range(0, 3); it.s1 = $urandom_range(0, 3);
    // hit the key colour often so overlay modes fire
    if ($urandom_range(0, 3) == 0) it.g0 = m_key[0];
    if ($urandom_range(0, 3) == 0) it.g1 = m_key[1];
    it.ch = $urandom_range(0, 3);
    it.idx = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
    it.val = $urandom;
    return it;
  endfunction

  // output side: random stall pattern plus one long hold
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) out_if.ready <= 1'b0;
      else if ($urandom_range(0, 63) < 8) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %06h %06h",
                                       out_if.rgb_first, out_if.rgb_second);
      end else begin
        rgb_pair_t e;
        e = pending_rgb.pop_front();
        if (out_if.rgb_first !== e.p0) flag_mismatch("rgb_first", e.p0, out_if.rgb_first);
        if (out_if.rgb_second !== e.p1) flag_mismatch("rgb_second", e.p1, out_if.rgb_second);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("yuv_layer_mix_gamma verification failed");
      $finish;
    end
  end

  pix_item_t dir_tab [$];
  logic [23:0] dir_exp [$];
  bit dir_has [$];

  function automatic void add_row(opcode_e op, logic [7:0] y0, logic [7:0] u,
                                  logic [7:0] y1, logic [7:0] v, logic [23:0] g0,
                                  logic [1:0] s0, logic [23:0] g1, logic [1:0] s1,
                                  logic [1:0] ch, logic [4:0] idx, logic [7:0] val,
                                  bit has, logic [23:0] e0);
    pix_item_t it;
    it = '{op, y0, u, y1, v, g0, s0, g1, s1, ch, idx, val};
    dir_tab.push_back(it);
    dir_has.push_back(has);
    dir_exp.push_back(e0);
  endfunction

  initial begin
    int sent;
    in_if.valid = 1'b0; in_if.opcode = OP_PIXEL;
    in_if.luma_first = '0; in_if.chroma_u = '0; in_if.luma_second = '0;
    in_if.chroma_v = '0; in_if.gfx_pixel_first = '0; in_if.gfx_source_first = '0;
    in_if.gfx_pixel_second = '0; in_if.gfx_source_second = '0;
    in_if.table_channel = '0; in_if.table_index = '0; in_if.table_value = '0;
    m_ctrl = '{0, 0}; m_key = '{0, 0}; m_ratio = '{0, 0}; m_gamma_en = 1'b0;
    for (int c = 0; c < GammaTables; c++)
      for (int p = 0; p < GammaPoints; p++) m_curve[c][p] = gamma_default(5'(p));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: extremes with expected first pixel where obvious
    add_row(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h008700);
    add_row(OP_PIXEL, 255, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0, 1, 24'hff79ff);
    add_row(OP_PIXEL, 128, 128, 255, 128, 24'h123456, 1, 24'hfedcba, 2, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 255, 255, 0, 24'hffffff, 3, 24'h0, 3, 3, 31, 255, 0, 0);
    add_row(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff, 0, 0);
    add_row(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 2, 16, 8'h00, 0, 0);
    add_row(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 3, 5, 8'h55, 0, 0);
    add_row(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 17, 8'h55, 0, 0);
    add_row(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 31, 8'haa, 0, 0);
    foreach (dir_tab[i]) begin
      if (dir_has[i]) begin
        rgb_pair_t e;
        send_pixels(dir_tab[i]);
        e = pending_rgb[pending_rgb.size() - 1];
        if (e.p0 !== dir_exp[i]) flag_mismatch("directed", dir_exp[i], e.p0);
      end else send_pixels(dir_tab[i]);
    end
    in_if.valid <= 1'b0;
    drain();

    // walk register settings, extremes included, then random bursts each
    for (int phase = 0; phase < 8; phase++) begin
      pix_item_t it;
      reg_write(REG_L0_CTRL, (phase == 0) ? 32'd1 : (phase == 1) ? 32'd31 : $urandom_range(0, 31));
      reg_write(REG_L1_CTRL, (phase == 2) ? 32'd0 : (phase == 3) ? 32'd31 : $urandom_range(0, 31));
      reg_write(REG_KEY0, (phase == 1) ? 32'hffffff : $urandom_range(0, 24'hffffff));
      reg_write(REG_KEY1, (phase == 3) ? 32'h0 : $urandom_range(0, 24'hffffff));
      reg_write(REG_RATIO0, (phase == 0) ? 32'd0 : (phase == 4) ? 32'd256 : $urandom_range(0, 511));
      reg_write(REG_RATIO1, (phase == 5) ? 32'd511 : (phase == 6) ? 32'd0 : $urandom_range(0, 256));
      reg_write(REG_GAMMA, phase[0]);
      sent = 0;
      while (sent < 95) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && sent < 95; b++) begin
          it = rand_item();
          send_pixels(it);
          sent++;
          // long receiver hold while the sender keeps going
          if (phase == 2 && sent == 10) begin
            fork
              begin
                long_hold = 1'b1;
                repeat (60) @(posedge clk_i);
                long_hold = 1'b0;
              end
            join_none
          end
        end
        if ($urandom_range(0, 2) != 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      in_if.valid <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("yuv_layer_mix_gamma verification clean");
    end else begin
      $display("yuv_layer_mix_gamma verification failed");
    end
    $finish;
  end

endmodule
